FILE: hdl/sra_pkg.sv
// Shared constants and field widths of the security region attribution block.
package sra_pkg;

    localparam int PROG_REGIONS  = 8;
    localparam int FIXED_REGIONS = 8;

    localparam int OpW      = 3;
    localparam int IndexW   = 3;
    localparam int AddrW    = 32;
    localparam int AttrW    = 2;
    localparam int DecW     = 2;
    // Wide enough to compare a table index against any entry number up to 16.
    localparam int IdxCmpW  = 5;

    localparam int InDataW  = 104;
    localparam int OutDataW = 8;

    // Operation codes carried in the input tuser.
    localparam logic [OpW-1:0] OP_WR_PROG  = 3'd0;
    localparam logic [OpW-1:0] OP_WR_FIXED = 3'd1;
    localparam logic [OpW-1:0] OP_ENABLE   = 3'd2;
    localparam logic [OpW-1:0] OP_CHECK    = 3'd3;
    localparam logic [OpW-1:0] OP_TO_SEC   = 3'd4;
    localparam logic [OpW-1:0] OP_TO_NSEC  = 3'd5;

    // Region attribute codes.
    localparam logic [AttrW-1:0] ATTR_NSEC    = 2'd0;
    localparam logic [AttrW-1:0] ATTR_SEC     = 2'd1;
    localparam logic [AttrW-1:0] ATTR_SEC_NSC = 2'd2;

    // What decided the answer of a check.
    localparam logic [DecW-1:0] DEC_WORLD = 2'd0;
    localparam logic [DecW-1:0] DEC_PROG  = 2'd1;
    localparam logic [DecW-1:0] DEC_FIXED = 2'd2;
    localparam logic [DecW-1:0] DEC_NONE  = 2'd3;

endpackage

FILE: hdl/security_region_attribution.sv
// Top level of the security region attribution block: region tables and address check.
//
// This block answers whether a 32-bit address is secure. It holds a table of programmable
// regions (base, inclusive limit, attribute) and a table of fixed-attribution regions (base,
// size, secure flag), a sticky unit enable and the current security world. Every input word
// carries an operation in s_axis_tuser: write a programmable region, write a fixed region,
// enable the unit, check an address, switch to the secure world, or switch to the non-secure
// world (which is only honoured while the callable-enable register is set). Only a check
// returns a word. While the unit is disabled the answer is the current world; otherwise the
// lowest-numbered matching programmable region decides, then the lowest-numbered matching
// fixed region, and an address that matches nothing is non-secure. A fixed region whose end
// wraps past the top of the address space matches nothing at all. The block takes one word
// per clock cycle when the output side keeps up. A check answer passes through the input
// register and then the result register. While a check answer waits in the result
// register, a following check waits in the input register and holds the input side off.
// There is one comparator pair per table entry, all working in parallel on the registered
// address. The end of each fixed region is summed when the region is written, so a check
// needs only compares. Table entries never written read as invalid; reset clears all valid
// bits at once, so there is no start-up sweep.
module security_region_attribution (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration: callable enable.
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    // Input words.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata fields from bit 0: region_index[2:0], region_base[34:3],
    // region_extent[66:35], region_attr[68:67], fixed_secure[69],
    // check_address[101:70], zero padding [103:102].
    input  logic [sra_pkg::InDataW-1:0]  s_axis_tdata,
    // tuser fields from bit 0: opcode[2:0].
    input  logic [sra_pkg::OpW-1:0]      s_axis_tuser,
    // Result words.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // tdata fields from bit 0: addr_secure[0], decided_by[2:1], zero padding [7:3].
    output logic [sra_pkg::OutDataW-1:0] m_axis_tdata
);

    // Configuration and world state.
    logic r_callable_en;
    logic r_world_secure;
    logic r_unit_en;

    // Input register stage.
    logic                         r_s1_valid;
    logic [sra_pkg::OpW-1:0]      r_s1_op;
    logic [sra_pkg::IndexW-1:0]   r_s1_index;
    logic [sra_pkg::AddrW-1:0]    r_s1_base;
    logic [sra_pkg::AddrW-1:0]    r_s1_extent;
    logic [sra_pkg::AttrW-1:0]    r_s1_attr;
    logic                         r_s1_fsec;
    logic [sra_pkg::AddrW-1:0]    r_s1_addr;

    // Region tables. The contents have no reset; the valid bits do.
    logic [sra_pkg::AddrW-1:0]    r_prog_base  [sra_pkg::PROG_REGIONS];
    logic [sra_pkg::AddrW-1:0]    r_prog_limit [sra_pkg::PROG_REGIONS];
    logic                         r_prog_sec   [sra_pkg::PROG_REGIONS];
    logic [sra_pkg::PROG_REGIONS-1:0] r_prog_valid;
    logic [sra_pkg::AddrW-1:0]    r_fix_base   [sra_pkg::FIXED_REGIONS];
    logic [sra_pkg::AddrW-1:0]    r_fix_end    [sra_pkg::FIXED_REGIONS];
    logic                         r_fix_sec    [sra_pkg::FIXED_REGIONS];
    logic [sra_pkg::FIXED_REGIONS-1:0] r_fix_valid;

    // Result register.
    logic                         r_m_valid;
    logic                         r_m_secure;
    logic [sra_pkg::DecW-1:0]     r_m_dec;

    logic                         out_free;
    logic                         s1_is_check;
    logic                         s1_go;
    logic                         s1_wr_prog;
    logic                         s1_wr_fix;
    logic [sra_pkg::IdxCmpW-1:0]  s1_index_ext;
    logic [sra_pkg::AddrW-1:0]    s1_fix_end;
    logic                         s1_attr_sec;
    logic [sra_pkg::PROG_REGIONS-1:0]  prog_match;
    logic [sra_pkg::FIXED_REGIONS-1:0] fix_match;
    logic                         prog_hit;
    logic                         prog_sec;
    logic                         fix_hit;
    logic                         fix_sec;
    logic                         n_m_secure;
    logic [sra_pkg::DecW-1:0]     n_m_dec;

    // ------------------------------------------------------------------
    // Handshake. A check needs a free result register; every other
    // operation completes in the stage itself and never stalls.
    // ------------------------------------------------------------------
    assign out_free      = !r_m_valid || m_axis_tready;
    assign s1_is_check   = (r_s1_op == sra_pkg::OP_CHECK);
    assign s1_go         = r_s1_valid && (!s1_is_check || out_free);
    assign s_axis_tready = !r_s1_valid || s1_go;

    assign s1_wr_prog    = s1_go && (r_s1_op == sra_pkg::OP_WR_PROG);
    assign s1_wr_fix     = s1_go && (r_s1_op == sra_pkg::OP_WR_FIXED);
    assign s1_index_ext  = sra_pkg::IdxCmpW'(r_s1_index);
    // The end address of a fixed region wraps at 32 bits.
    assign s1_fix_end    = r_s1_base + r_s1_extent;
    // Attribute code 3 is stored as non-secure.
    assign s1_attr_sec   = (r_s1_attr == sra_pkg::ATTR_SEC) ||
                           (r_s1_attr == sra_pkg::ATTR_SEC_NSC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_op     <= s_axis_tuser;
            r_s1_index  <= s_axis_tdata[2:0];
            r_s1_base   <= s_axis_tdata[34:3];
            r_s1_extent <= s_axis_tdata[66:35];
            r_s1_attr   <= s_axis_tdata[68:67];
            r_s1_fsec   <= s_axis_tdata[69];
            r_s1_addr   <= s_axis_tdata[101:70];
        end
    end

    // ------------------------------------------------------------------
    // World, unit enable and configuration.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_callable_en  <= 1'b0;
            r_world_secure <= 1'b1;
            r_unit_en      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_callable_en <= i_cfg_wdata;
            end
            if (s1_go && (r_s1_op == sra_pkg::OP_ENABLE)) begin
                r_unit_en <= 1'b1;
            end
            if (s1_go && (r_s1_op == sra_pkg::OP_TO_SEC)) begin
                r_world_secure <= 1'b1;
            end else if (s1_go && (r_s1_op == sra_pkg::OP_TO_NSEC) && r_callable_en) begin
                r_world_secure <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Table writes. An index beyond a table matches no entry and is dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_valid <= '0;
            r_fix_valid  <= '0;
        end else begin
            for (int i = 0; i < sra_pkg::PROG_REGIONS; i++) begin
                if (s1_wr_prog && (s1_index_ext == sra_pkg::IdxCmpW'(i))) begin
                    r_prog_valid[i] <= 1'b1;
                end
            end
            for (int i = 0; i < sra_pkg::FIXED_REGIONS; i++) begin
                if (s1_wr_fix && (s1_index_ext == sra_pkg::IdxCmpW'(i))) begin
                    r_fix_valid[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < sra_pkg::PROG_REGIONS; i++) begin
            if (s1_wr_prog && (s1_index_ext == sra_pkg::IdxCmpW'(i))) begin
                r_prog_base[i]  <= r_s1_base;
                r_prog_limit[i] <= r_s1_extent;
                r_prog_sec[i]   <= s1_attr_sec;
            end
        end
        for (int i = 0; i < sra_pkg::FIXED_REGIONS; i++) begin
            if (s1_wr_fix && (s1_index_ext == sra_pkg::IdxCmpW'(i))) begin
                r_fix_base[i] <= r_s1_base;
                r_fix_end[i]  <= s1_fix_end;
                r_fix_sec[i]  <= r_s1_fsec;
            end
        end
    end

    // ------------------------------------------------------------------
    // Address check: one comparator pair per entry, then a priority pick
    // of the lowest-numbered match in each table.
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < sra_pkg::PROG_REGIONS; i++) begin
            prog_match[i] = r_prog_valid[i] && (r_s1_addr >= r_prog_base[i]) &&
                            (r_s1_addr <= r_prog_limit[i]);
        end
        for (int i = 0; i < sra_pkg::FIXED_REGIONS; i++) begin
            fix_match[i] = r_fix_valid[i] && (r_s1_addr >= r_fix_base[i]) &&
                           (r_s1_addr < r_fix_end[i]);
        end
    end

    always_comb begin
        prog_hit = 1'b0;
        prog_sec = 1'b0;
        for (int i = sra_pkg::PROG_REGIONS - 1; i >= 0; i--) begin
            if (prog_match[i]) begin
                prog_hit = 1'b1;
                prog_sec = r_prog_sec[i];
            end
        end
        fix_hit = 1'b0;
        fix_sec = 1'b0;
        for (int i = sra_pkg::FIXED_REGIONS - 1; i >= 0; i--) begin
            if (fix_match[i]) begin
                fix_hit = 1'b1;
                fix_sec = r_fix_sec[i];
            end
        end
    end

    always_comb begin
        if (!r_unit_en) begin
            n_m_secure = r_world_secure;
            n_m_dec    = sra_pkg::DEC_WORLD;
        end else if (prog_hit) begin
            n_m_secure = prog_sec;
            n_m_dec    = sra_pkg::DEC_PROG;
        end else if (fix_hit) begin
            n_m_secure = fix_sec;
            n_m_dec    = sra_pkg::DEC_FIXED;
        end else begin
            n_m_secure = 1'b0;
            n_m_dec    = sra_pkg::DEC_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= s1_go && s1_is_check;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_is_check) begin
            r_m_secure <= n_m_secure;
            r_m_dec    <= n_m_dec;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(sra_pkg::OutDataW - sra_pkg::DecW - 1)'(0), r_m_dec, r_m_secure};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_disabled_answers_world: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_is_check && !r_unit_en) |=>
            (r_m_dec == sra_pkg::DEC_WORLD) && (r_m_secure == $past(r_world_secure)))
        else $error("check on a disabled unit did not answer with the world");

    a_prog_region_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_is_check && r_unit_en && (|prog_match)) |=>
            (r_m_dec == sra_pkg::DEC_PROG))
        else $error("programmable region match was not given priority");

    a_unit_enable_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unit_en |=> r_unit_en)
        else $error("unit enable dropped without reset");

    a_leave_secure_needs_callable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_world_secure) |-> $past(r_callable_en))
        else $error("left the secure world without callable enable");

endmodule
